/* rtl/core/cfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

    // request modes
    localparam logic [2:0] MODE_ENQ   = 3'd0;
    localparam logic [2:0] MODE_DEQ   = 3'd1;
    localparam logic [2:0] MODE_PEEK  = 3'd2;
    localparam logic [2:0] MODE_RIDX  = 3'd3;
    localparam logic [2:0] MODE_FIND  = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADIDX   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [3:0]         position;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [3:0]         found_at;
        logic [3:0]         count;
        logic               is_empty;
        logic               is_full;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } fsm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic issue_first;
        logic issue_next;
        logic finish_now;
        logic finish_read;
        logic finish_hit;
        logic finish_miss;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read;
        logic scan_go;
        logic hit;
        logic last;
    } ctl_sts_t;

endpackage

`default_nettype wire

/* rtl/core/cfs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfs_ctrl
    import cfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (sts.needs_read)
                    begin
                        cmd.issue_first = 1'b1;
                        state_next      = S_READ;
                    end
                    else if (sts.scan_go)
                    begin
                        cmd.issue_first = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        cmd.finish_now = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.finish_read = 1'b1;
                state_next      = S_IDLE;
            end
            S_SCAN:
            begin
                // one slot compared per cycle, next slot read in parallel
                if (sts.hit)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.last)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.issue_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/cfs_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfs_dpath
    import cfs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire ctl_cmd_t cmd,
    output ctl_sts_t      sts,
    output logic          done,
    output rsp_t          rsp
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int XW = (PW > 4) ? PW : 4;

    logic signed [31:0] slot_mem [DEPTH];

    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic [2:0]         mode_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] rd_data_reg;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic               wr_en;
    logic               rd_en;
    logic [PW-1:0]      rd_addr;
    logic [PW-1:0]      n_now;
    logic [PW-1:0]      n_after;
    logic               full_now;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      first_off;
    logic [XW-1:0]      found_x;
    logic [XW-1:0]      count_x;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // base + off mod DEPTH, off below DEPTH
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [XW-1:0] off);
        logic [XW:0] s;
        s = (XW+1)'(base) + (XW+1)'(off);
        if (s >= (XW+1)'(DEPTH))
        begin
            s = s - (XW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] held(input logic [PW-1:0] h,
                                           input logic [PW-1:0] t);
        logic [PW:0] d;
        if (t >= h)
        begin
            d = (PW+1)'(t) - (PW+1)'(h);
        end
        else
        begin
            d = (PW+1)'(t) + (PW+1)'(DEPTH) - (PW+1)'(h);
        end
        return d[PW-1:0];
    endfunction

    assign n_now    = held(head_reg, tail_reg);
    assign full_now = (ring_next(tail_reg) == head_reg);
    assign pos_x    = XW'(req.position);

    always_comb
    begin
        sts.needs_read = (((req.mode == MODE_DEQ) || (req.mode == MODE_PEEK))
                          && (n_now != '0))
                         || ((req.mode == MODE_RIDX) && (pos_x < XW'(n_now)));
        sts.scan_go    = (req.mode == MODE_FIND) && (n_now != '0);
        sts.hit        = (rd_data_reg == value_reg);
        sts.last       = ((PW+1)'(idx_reg) + (PW+1)'(1)) == (PW+1)'(n_now);
    end

    always_comb
    begin
        first_off = (req.mode == MODE_RIDX) ? pos_x : '0;
        if (cmd.issue_next)
        begin
            rd_addr = ring_add(head_reg, XW'(idx_reg) + XW'(1));
        end
        else
        begin
            rd_addr = ring_add(head_reg, first_off);
        end
        rd_en = cmd.issue_first | cmd.issue_next;
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        idx_next  = idx_reg;
        wr_en     = 1'b0;
        done_next = 1'b0;
        rsp_next  = '0;

        if (cmd.issue_first)
        begin
            idx_next = '0;
        end
        else if (cmd.issue_next)
        begin
            idx_next = idx_reg + PW'(1);
        end

        if (cmd.finish_now)
        begin
            done_next = 1'b1;
            case (req.mode) inside
                MODE_ENQ:
                begin
                    if (full_now)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        tail_next = ring_next(tail_reg);
                    end
                end
                MODE_DEQ, MODE_PEEK:
                begin
                    rsp_next.status = ST_EMPTY;
                end
                MODE_RIDX:
                begin
                    rsp_next.status = ST_BADIDX;
                end
                MODE_FIND:
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
                MODE_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.finish_read)
        begin
            done_next     = 1'b1;
            rsp_next.data = rd_data_reg;
            if (mode_reg == MODE_DEQ)
            begin
                head_next = ring_next(head_reg);
            end
        end

        found_x = XW'(idx_reg);
        if (cmd.finish_hit)
        begin
            done_next         = 1'b1;
            rsp_next.found_at = found_x[3:0];
        end

        if (cmd.finish_miss)
        begin
            done_next       = 1'b1;
            rsp_next.status = ST_NOTFOUND;
        end

        n_after           = held(head_next, tail_next);
        count_x           = XW'(n_after);
        rsp_next.count    = count_x[3:0];
        rsp_next.is_empty = (n_after == '0);
        rsp_next.is_full  = (ring_next(tail_next) == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.accept)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[tail_reg] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/circular_fifo_with_search.sv */
// Channel   Ports              Handshake
// request   req (req_t)        taken at clk edge with start=1 and busy=0
// result    rsp (rsp_t)        valid for the single cycle done=1, no backpressure
//
// Enqueue, clear and every error found at acceptance: busy stays low.
// Dequeue, peek, indexed read: pass through S_READ for the registered memory read.
// Find: scans in S_SCAN, 1 .. count slots compared, one per cycle on the
// single read port. The result appears the cycle after the item finishes.
// Reset clears head, tail and control; the slot memory is not cleared.
// The result side cannot stall; a new item may start while done is high.
`timescale 1ns / 1ps
`default_nettype none

module circular_fifo_with_search
    import cfs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    cfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    cfs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/cfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfs_assertions
    import cfs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    // an accepted item either keeps the block busy or answers next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor answered");

    // no answer without an item accepted or in progress
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(start && !busy) || $past(busy)))
        else $error("result without item");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.is_empty) |-> (rsp.count == 4'd0 && !rsp.is_full))
        else $error("empty flag inconsistent with count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> rsp.is_full)
        else $error("full status on non-full queue");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_EMPTY) |-> (rsp.is_empty && rsp.data == '0))
        else $error("empty status on non-empty queue");

endmodule

bind circular_fifo_with_search cfs_assertions u_cfs_assertions (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

/* test/cfs_checker.sv */
`timescale 1ns / 1ps

module cfs_checker
    import cfs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding
);

    logic signed [31:0] slot_mem [DEPTH];
    int                 head_ptr;
    int                 tail_ptr;
    int                 mismatches = 0;
    rsp_t               pending_results [$];

    function automatic int held_items();
        return (tail_ptr + DEPTH - head_ptr) % DEPTH;
    endfunction

    function automatic logic ring_full();
        return ((tail_ptr + 1) % DEPTH) == head_ptr;
    endfunction

    // apply one request to the shadow ring and return the result it yields
    function automatic rsp_t predict_fifo_op(input req_t r);
        rsp_t res;
        int   n;
        res        = '0;
        res.status = ST_OK;
        n          = held_items();
        case (r.mode)
            MODE_ENQ:
            begin
                if (ring_full())
                    res.status = ST_FULL;
                else
                begin
                    slot_mem[tail_ptr] = r.value;
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                end
            end
            MODE_DEQ, MODE_PEEK:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.data = slot_mem[head_ptr];
                    if (r.mode == MODE_DEQ)
                        head_ptr = (head_ptr + 1) % DEPTH;
                end
            end
            MODE_RIDX:
            begin
                if (int'(r.position) >= n)
                    res.status = ST_BADIDX;
                else
                    res.data = slot_mem[(head_ptr + int'(r.position)) % DEPTH];
            end
            MODE_FIND:
            begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++)
                begin
                    if (slot_mem[(head_ptr + i) % DEPTH] == r.value)
                    begin
                        res.status   = ST_OK;
                        res.found_at = 4'(i);
                        break;
                    end
                end
            end
            MODE_CLEAR:
            begin
                // stored words stay, only the pointers go back
                head_ptr = 0;
                tail_ptr = 0;
            end
            default:
            begin
            end
        endcase
        n            = held_items();
        res.count    = 4'(n);
        res.is_empty = (n == 0);
        res.is_full  = ring_full();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            head_ptr = 0;
            tail_ptr = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // result first: a new item may be taken on the same edge
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("data", want.data, rsp.data);
                    check_field("found_at", 32'(want.found_at), 32'(rsp.found_at));
                    check_field("count", 32'(want.count), 32'(rsp.count));
                    check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
                end
            end
            if (start && !busy)
                pending_results.push_back(predict_fifo_op(req));
            outstanding <= pending_results.size();
        end
        errors <= mismatches;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cfs_pkg::*;

    localparam int DEPTH = 16;
    localparam int PHASE_ITEMS = 467;
    // codes with no operation behind them
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;
    int   errors;
    int   outstanding;
    int   idle_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    circular_fifo_with_search #(.DEPTH(DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    cfs_checker #(.DEPTH(DEPTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // returns on the edge that takes the item
    task automatic push_item(input logic [2:0] mode, input logic signed [31:0] value,
                             input logic [3:0] position);
        req_t r;
        r.mode     = mode;
        r.value    = value;
        r.position = position;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // small pool so searches hit often, plus fully random words
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sh5555_5555;
            5:       return 32'shaaaa_aaaa;
            6:       return 32'sd42;
            7:       return 32'sd7;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode(input int enq_pct);
        int r;
        if ($urandom_range(99) < enq_pct)
            return MODE_ENQ;
        r = $urandom_range(99);
        if (r < 32)
            return MODE_DEQ;
        else if (r < 44)
            return MODE_PEEK;
        else if (r < 66)
            return MODE_RIDX;
        else if (r < 94)
            return MODE_FIND;
        else if (r < 96)
            return MODE_CLEAR;
        else if (r < 98)
            return MODE_SPARE_LO;
        else
            return MODE_SPARE_HI;
    endfunction

    initial
    begin
        int enq_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(MODE_ENQ, 32'sh8000_0000, 4'd0);
        push_item(MODE_ENQ, 32'sh7fff_ffff, 4'd15);
        push_item(MODE_ENQ, 32'sh0000_0000, 4'd0);
        push_item(MODE_ENQ, -32'sd1, 4'd15);
        push_item(MODE_PEEK, 32'sd0, 4'd0);
        push_item(MODE_RIDX, 32'sd0, 4'd3);
        push_item(MODE_RIDX, 32'sd0, 4'd4);     // equals the count, one past the last slot
        push_item(MODE_RIDX, 32'sd0, 4'd15);
        push_item(MODE_FIND, 32'sh7fff_ffff, 4'd0);
        push_item(MODE_FIND, -32'sd1, 4'd0);    // match in the last slot
        push_item(MODE_FIND, 32'sd12345, 4'd0); // no match
        push_item(MODE_DEQ, 32'sd0, 4'd0);
        push_item(MODE_SPARE_LO, -32'sd1, 4'd15);
        push_item(MODE_SPARE_HI, 32'sd0, 4'd0);
        push_item(MODE_CLEAR, 32'sd0, 4'd0);
        push_item(MODE_DEQ, 32'sd0, 4'd0);
        push_item(MODE_PEEK, 32'sd0, 4'd0);
        push_item(MODE_RIDX, 32'sd0, 4'd0);
        push_item(MODE_FIND, 32'sd0, 4'd0);     // stale words must not match
        for (int i = 0; i < DEPTH; i++)
            push_item(MODE_ENQ, 32'sd100 + i, 4'd0); // last one hits full
        push_item(MODE_FIND, 32'sd100 + DEPTH - 2, 4'd0);
        push_item(MODE_RIDX, 32'sd0, 4'(DEPTH - 2));

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 88 : 0;
            enq_pct  = 55;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and draining so both ends are reached
                if (i % 40 == 0)
                    enq_pct = (enq_pct == 55) ? 15 : 55;
                push_item(pick_mode(enq_pct), pick_value(), 4'($urandom_range(15)));
            end
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
